// File: hdl/tcp_scan_detector_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the TCP scan detector
// Concurrent check wrappers, compiled away for synthesis.
// ----------------------------------------------------------------------------
`ifndef TCP_SCAN_DETECTOR_CORE_MACROS_SVH
`define TCP_SCAN_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsd check failed");
// next-cycle implication
`define TSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsd check failed");
`else
`define TSD_ASSERT_NOW(label, ante, cons)
`define TSD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants of the TCP scan detector.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int ADDR_W    = 32;
  localparam int TIME_W    = 63;
  localparam int CNT_W     = 16;
  localparam int TMO_W     = 8;
  localparam int LIMIT_W   = 38;   // (255+1) s in ns fits in 38 bits
  localparam int PADDR_W   = 5;
  localparam int OUTQ_AW   = 2;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_CW   = 3;

  localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
  localparam logic [CNT_W-1:0] RESET_THRESHOLD = 16'd200;
  localparam logic [TMO_W-1:0] RESET_TIMEOUT = 8'd5;
  localparam logic [63:0] LIMIT_RESET_FULL = (64'(RESET_TIMEOUT) + 64'd1) * NS_PER_SEC;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_RESET_FULL[LIMIT_W-1:0];

  localparam logic [7:0] TCP_PROTOCOL = 8'd6;

  // exact flag patterns per class
  localparam logic [5:0] FLAGS_SYN  = 6'h02;
  localparam logic [5:0] FLAGS_NULL = 6'h00;
  localparam logic [5:0] FLAGS_XMAS = 6'h29;
  localparam logic [5:0] FLAGS_FIN  = 6'h01;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_SYN_THR  = 3'd0;
  localparam logic [2:0] REG_NULL_THR = 3'd1;
  localparam logic [2:0] REG_XMAS_THR = 3'd2;
  localparam logic [2:0] REG_FIN_THR  = 3'd3;
  localparam logic [2:0] REG_TIMEOUT  = 3'd4;

  typedef enum logic [2:0] {
    KIND_SYN  = 3'd0,
    KIND_NULL = 3'd1,
    KIND_XMAS = 3'd2,
    KIND_FIN  = 3'd3,
    KIND_NONE = 3'd4
  } kind_t;

  typedef struct packed {
    logic [3:0][CNT_W-1:0] thr;       // indexed by class
    logic [LIMIT_W-1:0]    limit_ns;  // (timeout + 1) seconds in ns
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] src;
    logic [TIME_W-1:0] last_time;
    logic [CNT_W-1:0]  count;
  } entry_t;

  typedef struct packed {
    kind_t             kind;
    logic              alert;
    logic [ADDR_W-1:0] alert_address;
  } result_t;

endpackage

// File: hdl/tcp_scan_detector_core.sv
// Each item passes the tracker stage, then the result queue.
// Throughput: one item per cycle; set by the tracker's read-modify-write
// of the class memory, with the previous write forwarded.
// Input stalls while the result queue and the tracker stage together hold four items.
// Reset (rst, synchronous): trackers read as zero, queue empties, thresholds 200, timeout 5 s.
// ----------------------------------------------------------------------------
// tcp_scan_detector_core
// TCP flag scan detector: classifies packets and alerts per class threshold.
// ----------------------------------------------------------------------------
module tcp_scan_detector_core
  import tsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         protocol,
  input  logic [ADDR_W-1:0]  source_address,
  input  logic [5:0]         tcp_flags,
  input  logic [TIME_W-1:0]  arrival_time_ns,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         scan_kind,
  output logic               alert,
  output logic [ADDR_W-1:0]  alert_address,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t               cfg;
  logic               acc;
  logic               busy;
  logic               res_valid;
  result_t            res;
  result_t            head;
  logic [OUTQ_CW-1:0] q_count;
  logic [OUTQ_CW-1:0] in_flight;

  tsd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // room for the item in the tracker stage plus everything queued
  assign in_flight = q_count + OUTQ_CW'(busy);
  assign in_ready  = (in_flight < OUTQ_CW'(OUTQ_DEPTH));
  assign acc       = in_valid && in_ready;

  tsd_tracker u_tracker (
    .clk             (clk),
    .rst             (rst),
    .acc             (acc),
    .protocol        (protocol),
    .source_address  (source_address),
    .tcp_flags       (tcp_flags),
    .arrival_time_ns (arrival_time_ns),
    .cfg             (cfg),
    .busy            (busy),
    .res_valid       (res_valid),
    .res             (res)
  );

  tsd_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .pop        (out_valid && out_ready),
    .head_valid (out_valid),
    .head       (head),
    .count      (q_count)
  );

  assign scan_kind     = head.kind;
  assign alert         = head.alert;
  assign alert_address = head.alert_address;

endmodule

// File: hdl/tsd_regs.sv
// ----------------------------------------------------------------------------
// tsd_regs
// APB configuration registers: class thresholds and scan timeout.
// ----------------------------------------------------------------------------
module tsd_regs
  import tsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [TMO_W-1:0] timeout;
  logic [2:0]       idx;
  logic             wr;
  logic [63:0]      limit_full;

  assign pready = 1'b1;
  assign idx = paddr[PADDR_W-1:2];
  assign wr = psel && penable && pwrite;
  // (t + 1) * 1e9: narrow operand times a constant
  assign limit_full = (64'(pwdata[TMO_W-1:0]) + 64'd1) * NS_PER_SEC;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr      <= {4{RESET_THRESHOLD}};
      cfg.limit_ns <= LIMIT_RESET;
      timeout      <= RESET_TIMEOUT;
    end else if (wr) begin
      unique case (idx)
        REG_SYN_THR:  cfg.thr[0] <= pwdata[CNT_W-1:0];
        REG_NULL_THR: cfg.thr[1] <= pwdata[CNT_W-1:0];
        REG_XMAS_THR: cfg.thr[2] <= pwdata[CNT_W-1:0];
        REG_FIN_THR:  cfg.thr[3] <= pwdata[CNT_W-1:0];
        REG_TIMEOUT: begin
          timeout      <= pwdata[TMO_W-1:0];
          cfg.limit_ns <= limit_full[LIMIT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SYN_THR:  prdata = 32'(cfg.thr[0]);
      REG_NULL_THR: prdata = 32'(cfg.thr[1]);
      REG_XMAS_THR: prdata = 32'(cfg.thr[2]);
      REG_FIN_THR:  prdata = 32'(cfg.thr[3]);
      REG_TIMEOUT:  prdata = 32'(timeout);
      default:      prdata = '0;
    endcase
  end

endmodule

// File: hdl/tsd_tracker.sv
// ----------------------------------------------------------------------------
// tsd_tracker
// Per-class tracker memory with read-modify-write and forwarding.
// ----------------------------------------------------------------------------
module tsd_tracker
  import tsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              acc,
  input  logic [7:0]        protocol,
  input  logic [ADDR_W-1:0] source_address,
  input  logic [5:0]        tcp_flags,
  input  logic [TIME_W-1:0] arrival_time_ns,
  input  cfg_t              cfg,
  output logic              busy,
  output logic              res_valid,
  output result_t           res
);

  `include "tcp_scan_detector_core_macros.svh"

  entry_t mem [4];
  entry_t rd_ent;
  logic [3:0] ent_valid;       // entry written since reset, else reads as zero

  kind_t kind;

  logic              s1_valid;
  kind_t             s1_kind;
  logic [ADDR_W-1:0] s1_src;
  logic [TIME_W-1:0] s1_now;

  logic       fwd_valid;
  logic [1:0] fwd_idx;
  entry_t     fwd_ent;

  entry_t     cur;
  entry_t     wr_ent;
  logic       wr_en;
  logic [1:0] s1_idx;
  logic       same;
  logic [63:0] diff;
  logic       timely;
  logic [CNT_W-1:0] cnt_inc;
  logic       hit;
  logic       alarm;

  always_comb begin
    kind = KIND_NONE;
    if (protocol == TCP_PROTOCOL) begin
      case (tcp_flags)
        FLAGS_SYN:  kind = KIND_SYN;
        FLAGS_NULL: kind = KIND_NULL;
        FLAGS_XMAS: kind = KIND_XMAS;
        FLAGS_FIN:  kind = KIND_FIN;
        default:    kind = KIND_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_idx] <= wr_ent;
    end
    if (acc) begin
      rd_ent <= mem[kind[1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      ent_valid <= '0;
    end else begin
      s1_valid  <= acc;
      fwd_valid <= wr_en;
      if (wr_en) begin
        ent_valid[s1_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_kind <= kind;
      s1_src  <= source_address;
      s1_now  <= arrival_time_ns;
    end
    if (wr_en) begin
      fwd_idx <= s1_idx;
      fwd_ent <= wr_ent;
    end
  end

  assign s1_idx = s1_kind[1:0];
  assign wr_en  = s1_valid && (s1_kind != KIND_NONE);

  always_comb begin
    // write from the previous cycle has not reached the read data yet
    if (fwd_valid && (fwd_idx == s1_idx)) begin
      cur = fwd_ent;
    end else if (ent_valid[s1_idx]) begin
      cur = rd_ent;
    end else begin
      cur = '0;
    end

    same    = (cur.src == s1_src);
    diff    = {1'b0, s1_now} - {1'b0, cur.last_time};
    // negative gap always counts
    timely  = diff[63] ||
              ((diff[62:LIMIT_W] == '0) && (diff[LIMIT_W-1:0] < cfg.limit_ns));
    cnt_inc = cur.count + 16'd1;
    hit     = same && timely;
    alarm   = hit && (cnt_inc >= cfg.thr[s1_idx]);

    wr_ent.src       = s1_src;
    wr_ent.last_time = s1_now;
    if (!same || alarm) begin
      wr_ent.count = '0;
    end else if (hit) begin
      wr_ent.count = cnt_inc;
    end else begin
      wr_ent.count = cur.count;
    end

    res.kind          = s1_kind;
    res.alert         = wr_en && alarm;
    res.alert_address = (wr_en && alarm) ? cur.src : '0;
  end

  assign res_valid = s1_valid;
  assign busy      = s1_valid;

  `TSD_ASSERT_NOW(a_alert_has_class, res_valid && res.alert, res.kind != KIND_NONE)
  `TSD_ASSERT_NOW(a_quiet_addr_zero, res_valid && !res.alert, res.alert_address == '0)
  `TSD_ASSERT_NOW(a_alert_clears_count, res_valid && res.alert, wr_ent.count == '0)
  `TSD_ASSERT_NEXT(a_write_forwarded, wr_en, fwd_valid && (fwd_idx == $past(s1_idx)))

endmodule

// File: hdl/tsd_outq.sv
// ----------------------------------------------------------------------------
// tsd_outq
// Small result queue that decouples the tracker from output backpressure.
// ----------------------------------------------------------------------------
module tsd_outq
  import tsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  result_t            push_data,
  input  logic               pop,
  output logic               head_valid,
  output result_t            head,
  output logic [OUTQ_CW-1:0] count
);

  result_t q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_ptr;
  logic [OUTQ_AW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];

endmodule
